>>> src/scm_pkg.sv
// ----------------------------------------------------------------------------
// Size class mapper package
// Request and response types, tier constants and pipeline stage types.
// ----------------------------------------------------------------------------
package scm_pkg;

  localparam int unsigned MAX_SMALL_BYTES = 262144;
  localparam int unsigned PAGE_BITS       = 13;

  localparam int unsigned REQ_W  = 31;
  localparam int unsigned OBJ_W  = 19;
  localparam int unsigned CNT_W  = 10;
  localparam int unsigned IDX_W  = 8;

  localparam logic [REQ_W-1:0] TIER0_TOP = REQ_W'(128);
  localparam logic [REQ_W-1:0] TIER1_TOP = REQ_W'(1024);
  localparam logic [REQ_W-1:0] TIER2_TOP = REQ_W'(8 << 10);
  localparam logic [REQ_W-1:0] TIER3_TOP = REQ_W'(64 << 10);
  localparam logic [REQ_W-1:0] TIER4_TOP = REQ_W'(256 << 10);
  localparam logic [REQ_W-1:0] REQ_TOP   = REQ_W'(1 << 30);
  localparam logic [REQ_W-1:0] SMALL_TOP = REQ_W'(MAX_SMALL_BYTES);

  localparam int unsigned TIER_BUCKETS [4] = '{16, 56, 56, 56};
  localparam logic [IDX_W-1:0] BASE1 = IDX_W'(TIER_BUCKETS[0]);
  localparam logic [IDX_W-1:0] BASE2 = IDX_W'(TIER_BUCKETS[0] + TIER_BUCKETS[1]);
  localparam logic [IDX_W-1:0] BASE3 =
    IDX_W'(TIER_BUCKETS[0] + TIER_BUCKETS[1] + TIER_BUCKETS[2]);
  localparam logic [IDX_W-1:0] BASE4 =
    IDX_W'(TIER_BUCKETS[0] + TIER_BUCKETS[1] + TIER_BUCKETS[2] + TIER_BUCKETS[3]);
  localparam logic [IDX_W-1:0] BUCKET_LAST = IDX_W'(207);

  localparam int unsigned BATCH_MIN = 2;
  localparam int unsigned BATCH_MAX = 512;
  localparam int unsigned QUO_W     = 9;
  localparam int unsigned DVS_W     = OBJ_W + QUO_W;
  localparam int unsigned STEPS_PER_STAGE = 3;

  typedef struct packed {
    logic [REQ_W-1:0] request_bytes;
    logic [OBJ_W-1:0] object_size;
  } req_t;

  typedef struct packed {
    logic [REQ_W-1:0] aligned_bytes;
    logic [IDX_W-1:0] bucket_index;
    logic             index_valid;
    logic [CNT_W-1:0] batch_objects;
    logic [CNT_W-1:0] batch_pages;
    logic             move_valid;
  } rsp_t;

  typedef struct packed {
    logic [REQ_W-1:0] aligned_bytes;
    logic [IDX_W-1:0] bucket_index;
    logic             index_valid;
  } map_t;

  typedef struct packed {
    map_t             map;
    logic [OBJ_W-1:0] obj;
    logic [OBJ_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
    logic [QUO_W-1:0] quo;
  } div_t;

endpackage

>>> src/scm_req_map.sv
// ----------------------------------------------------------------------------
// Request size mapping
// Rounds the request up to its tier alignment and derives its bucket index.
// ----------------------------------------------------------------------------
module scm_req_map (
  input  logic [scm_pkg::REQ_W-1:0] request_bytes,
  output scm_pkg::map_t             map
);
  import scm_pkg::*;

  logic [REQ_W-1:0] r;
  logic             in_range;
  logic             in_small;
  logic [4:0]       sh;
  logic [OBJ_W-1:0] start;
  logic [IDX_W-1:0] base;
  logic [REQ_W-1:0] amask;
  logic [OBJ_W-1:0] off;
  logic [OBJ_W-1:0] bsum;
  logic [OBJ_W-1:0] bidx;

  always_comb begin
    r        = request_bytes;
    in_range = (r != '0) && (r <= REQ_TOP);
    in_small = in_range && (r <= SMALL_TOP) && (r <= TIER4_TOP);
    if (r <= TIER0_TOP) begin
      sh = 5'd3;
      start = '0;
      base = '0;
    end else if (r <= TIER1_TOP) begin
      sh = 5'd4;
      start = OBJ_W'(TIER0_TOP);
      base = BASE1;
    end else if (r <= TIER2_TOP) begin
      sh = 5'd7;
      start = OBJ_W'(TIER1_TOP);
      base = BASE2;
    end else if (r <= TIER3_TOP) begin
      sh = 5'd10;
      start = OBJ_W'(TIER2_TOP);
      base = BASE3;
    end else if (r <= TIER4_TOP) begin
      sh = 5'd13;
      start = OBJ_W'(TIER3_TOP);
      base = BASE4;
    end else begin
      sh = 5'(PAGE_BITS);
      start = '0;
      base = '0;
    end
    amask = (REQ_W'(1) << sh) - REQ_W'(1);
    off   = r[OBJ_W-1:0] - start;
    bsum  = off + amask[OBJ_W-1:0];
    bidx  = bsum >> sh;
    map.aligned_bytes = in_range ? ((r + amask) & ~amask) : '0;
    map.index_valid   = in_small;
    map.bucket_index  = in_small ? (bidx[IDX_W-1:0] - IDX_W'(1) + base) : '0;
  end

endmodule

>>> src/scm_div_step.sv
// ----------------------------------------------------------------------------
// Divider stage
// Three restoring division steps of the batch quotient, then a register.
// ----------------------------------------------------------------------------
module scm_div_step (
  input  logic          clk,
  input  logic          en,
  input  scm_pkg::div_t d,
  output scm_pkg::div_t q
);
  import scm_pkg::*;

  div_t q_next;

  always_comb begin
    q_next = d;
    for (int k = 0; k < STEPS_PER_STAGE; k++) begin
      if ({{QUO_W{1'b0}}, q_next.rem} >= q_next.dvs) begin
        q_next.rem = q_next.rem - q_next.dvs[OBJ_W-1:0];
        q_next.quo = {q_next.quo[QUO_W-2:0], 1'b1};
      end else begin
        q_next.quo = {q_next.quo[QUO_W-2:0], 1'b0};
      end
      q_next.dvs = q_next.dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end

endmodule

>>> src/scm_batch.sv
// ----------------------------------------------------------------------------
// Batch stage
// Clamps the batch quotient, computes the page count and holds the response.
// ----------------------------------------------------------------------------
module scm_batch (
  input  logic          clk,
  input  logic          en,
  input  scm_pkg::div_t d,
  output scm_pkg::rsp_t rsp
);
  import scm_pkg::*;

  logic                     ok;
  logic [CNT_W-1:0]         batch;
  logic [OBJ_W+CNT_W-1:0]   prod;
  logic [OBJ_W+CNT_W-1:0]   pg;
  logic [CNT_W-1:0]         pages;
  rsp_t                     rsp_next;

  always_comb begin
    ok = (d.obj != '0) && (d.obj <= OBJ_W'(MAX_SMALL_BYTES));
    if (d.obj <= OBJ_W'(MAX_SMALL_BYTES / BATCH_MAX)) begin
      batch = CNT_W'(BATCH_MAX);
    end else if (d.quo < QUO_W'(BATCH_MIN)) begin
      batch = CNT_W'(BATCH_MIN);
    end else begin
      batch = CNT_W'(d.quo);
    end
    prod  = (OBJ_W+CNT_W)'(batch) * (OBJ_W+CNT_W)'(d.obj);
    pg    = prod >> PAGE_BITS;
    pages = (pg == '0) ? CNT_W'(1) : pg[CNT_W-1:0];
    rsp_next.aligned_bytes = d.map.aligned_bytes;
    rsp_next.bucket_index  = d.map.bucket_index;
    rsp_next.index_valid   = d.map.index_valid;
    rsp_next.batch_objects = ok ? batch : '0;
    rsp_next.batch_pages   = ok ? pages : '0;
    rsp_next.move_valid    = ok;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> src/size_class_mapper.sv
// ----------------------------------------------------------------------------
// Size class mapper
// Maps a request size to its aligned size and bucket, and an object size to
// its transfer batch and page count, in a four stage pipeline.
//
//   Channel   Handshake              Payload
//   request   req_valid, req_stall   req  (request_bytes, object_size)
//   response  rsp_valid, rsp_stall   rsp  (aligned_bytes ... move_valid)
//
// A request accepted at a clock edge passes four register stages to the
// response, and a new request can be accepted every cycle unless req_stall
// is raised by a stalled, full pipeline. The batch divider resolves three
// quotient bits per stage over three stages before the clamp and page
// multiply stage. Reset clears all stage valid bits. A response stall holds
// the output register and backs up the stages behind it; no request is lost
// or repeated.
// ----------------------------------------------------------------------------
module size_class_mapper (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  scm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output scm_pkg::rsp_t rsp
);
  import scm_pkg::*;

  logic v1;
  logic v2;
  logic v3;
  logic v1_next;
  logic v2_next;
  logic v3_next;
  logic v4_next;
  logic en1;
  logic en2;
  logic en3;
  logic en4;
  map_t map;
  div_t s0;
  div_t s1;
  div_t s2;
  div_t s3;

  assign en4 = !rsp_valid || !rsp_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req_stall = !en1;

  assign v1_next = en1 ? req_valid : v1;
  assign v2_next = en2 ? v1 : v2;
  assign v3_next = en3 ? v2 : v3;
  assign v4_next = en4 ? v3 : rsp_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      v1 <= v1_next;
      v2 <= v2_next;
      v3 <= v3_next;
      rsp_valid <= v4_next;
    end
  end

  scm_req_map u_map (
    .request_bytes (req.request_bytes),
    .map           (map)
  );

  always_comb begin
    s0.map = map;
    s0.obj = req.object_size;
    s0.rem = OBJ_W'(MAX_SMALL_BYTES);
    s0.dvs = DVS_W'(req.object_size) << (QUO_W - 1);
    s0.quo = '0;
  end

  scm_div_step u_div1 (.clk(clk), .en(en1), .d(s0), .q(s1));
  scm_div_step u_div2 (.clk(clk), .en(en2), .d(s1), .q(s2));
  scm_div_step u_div3 (.clk(clk), .en(en3), .d(s2), .q(s3));

  scm_batch u_batch (
    .clk (clk),
    .en  (en4),
    .d   (s3),
    .rsp (rsp)
  );

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.index_valid) |-> (rsp.bucket_index <= BUCKET_LAST))
    else $error("bucket index beyond last bucket");

  a_bucket_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.index_valid) |-> (rsp.bucket_index == '0))
    else $error("bucket index nonzero for an invalid request");

  a_batch_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.move_valid) |->
      ((rsp.batch_objects >= CNT_W'(BATCH_MIN)) &&
       (rsp.batch_objects <= CNT_W'(BATCH_MAX)) && (rsp.batch_pages != '0)))
    else $error("batch count out of range");

  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    (v3 && en4) |=> rsp_valid)
    else $error("request lost between last stages");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (v1 && v2 && v3 && rsp_valid && rsp_stall))
    else $error("input stalled while pipeline has room");

endmodule

>>> sim/size_class_mapper_tb.sv
// ----------------------------------------------------------------------------
// Size class mapper testbench
// Drives requests through the valid/stall channel and checks every response
// against an in-bench size class calculation. The run starts with tier
// boundary cases, then sends random requests in four phases of varied send idling and response stalling.
// ----------------------------------------------------------------------------
module size_class_mapper_tb;

  import scm_pkg::*;

  localparam longint unsigned TOP_8B   = 128;
  localparam longint unsigned TOP_16B  = 1024;
  localparam longint unsigned TOP_128B = 8192;
  localparam longint unsigned TOP_1K   = 65536;
  localparam longint unsigned TOP_8K   = 262144;
  localparam longint unsigned TOP_PAGE = 64'd1 << 30;
  localparam longint unsigned MIN_BATCH = 2;
  localparam longint unsigned MAX_BATCH = 512;
  localparam int unsigned PHASE_REQS = 238;
  localparam int unsigned HANG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int unsigned send_idle_pct = 0;
  int unsigned rsp_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned hang_cycles = 0;

  size_class_mapper dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always #4 clk = ~clk;

  function automatic rsp_t map_request(req_t r);
    longint unsigned sz;
    longint unsigned obj;
    longint unsigned step;
    longint unsigned off;
    longint unsigned base;
    longint unsigned cnt;
    longint unsigned pg;
    longint unsigned aligned;
    longint unsigned bucket;
    int unsigned sh;
    rsp_t m;
    m = '0;
    sz = r.request_bytes;
    obj = r.object_size;
    off = 0;
    base = 0;
    if (sz >= 1 && sz <= TOP_PAGE) begin
      if (sz <= TOP_8B) begin
        sh = 3;
        off = sz;
        base = 0;
      end else if (sz <= TOP_16B) begin
        sh = 4;
        off = sz - TOP_8B;
        base = 16;
      end else if (sz <= TOP_128B) begin
        sh = 7;
        off = sz - TOP_16B;
        base = 72;
      end else if (sz <= TOP_1K) begin
        sh = 10;
        off = sz - TOP_128B;
        base = 128;
      end else if (sz <= TOP_8K) begin
        sh = 13;
        off = sz - TOP_1K;
        base = 184;
      end else begin
        sh = PAGE_BITS;
      end
      step = 64'd1 << sh;
      aligned = (sz + step - 1) & ~(step - 1);
      m.aligned_bytes = aligned[30:0];
      if (sz <= TOP_8K && sz <= MAX_SMALL_BYTES) begin
        bucket = ((off + step - 1) >> sh) - 1 + base;
        m.index_valid = 1'b1;
        m.bucket_index = bucket[7:0];
      end
    end
    if (obj >= 1 && obj <= MAX_SMALL_BYTES) begin
      cnt = MAX_SMALL_BYTES / obj;
      if (cnt < MIN_BATCH) cnt = MIN_BATCH;
      else if (cnt > MAX_BATCH) cnt = MAX_BATCH;
      pg = (cnt * obj) >> PAGE_BITS;
      if (pg == 0) pg = 1;
      m.move_valid = 1'b1;
      m.batch_objects = cnt[9:0];
      m.batch_pages = pg[9:0];
    end
    return m;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic push_req(longint unsigned bytes, longint unsigned obj);
    req_t r;
    r.request_bytes = bytes[30:0];
    r.object_size = obj[18:0];
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct);
    longint unsigned tops[6];
    longint unsigned bytes;
    longint unsigned obj;
    tops = '{TOP_8B, TOP_16B, TOP_128B, TOP_1K, TOP_8K, TOP_PAGE};
    send_idle_pct = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (PHASE_REQS) begin
      case ($urandom_range(0, 9))
        0: bytes = $urandom_range(1, 128);
        1: bytes = $urandom_range(129, 1024);
        2: bytes = $urandom_range(1025, 8192);
        3: bytes = $urandom_range(8193, 65536);
        4: bytes = $urandom_range(65537, 262144);
        5: bytes = $urandom_range(262145, 32'h4000_0000);
        6: bytes = $urandom_range(32'h4000_0001, 32'h7FFF_FFFF);
        7: bytes = tops[$urandom_range(0, 5)] + $urandom_range(0, 2) - 1;
        8: bytes = $urandom_range(0, 3);
        default: bytes = $urandom() & 32'h7FFF_FFFF;
      endcase
      case ($urandom_range(0, 7))
        0: obj = $urandom_range(1, 512);
        1: obj = $urandom_range(513, 131072);
        2: obj = $urandom_range(131073, 262144);
        3: obj = $urandom_range(262145, 524287);
        4: obj = 0;
        5: obj = $urandom() & 32'h7FFFF;
        6: obj = $urandom_range(1, 8192);
        default: obj = $urandom_range(1, 262144);
      endcase
      push_req(bytes, obj);
    end
    wait_drained();
  endtask

  always @(posedge clk) begin : driver
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_valid) expected_rsps.push_back(map_request(req));
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $error("response with no request outstanding");
        mismatches++;
      end else begin
        want = expected_rsps.pop_front();
        check_field("aligned_bytes", want.aligned_bytes, rsp.aligned_bytes);
        check_field("bucket_index", want.bucket_index, rsp.bucket_index);
        check_field("index_valid", want.index_valid, rsp.index_valid);
        check_field("batch_objects", want.batch_objects, rsp.batch_objects);
        check_field("batch_pages", want.batch_pages, rsp.batch_pages);
        check_field("move_valid", want.move_valid, rsp.move_valid);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (pending_reqs.size() == 0 && expected_rsps.size() == 0 && !req_valid)) begin
        hang_cycles <= 0;
      end else if (hang_cycles >= HANG_LIMIT) begin
        $display("FAIL size_class_mapper");
        $finish;
      end else begin
        hang_cycles <= hang_cycles + 1;
      end
    end
  end

  initial begin
    push_req(0, 0);
    push_req(1, 1);
    push_req(8, 2);
    push_req(9, 512);
    push_req(128, 513);
    push_req(129, 8191);
    push_req(1024, 8192);
    push_req(1025, 131072);
    push_req(8192, 131073);
    push_req(8193, 262144);
    push_req(65536, 262145);
    push_req(65537, 524287);
    push_req(262144, 100);
    push_req(262145, 3000);
    push_req(TOP_PAGE, 65536);
    push_req(TOP_PAGE + 1, 7);
    push_req(64'h7FFF_FFFF, 64'h7FFFF);
    push_req(64'h2AAA_AAAA, 64'h2AAAA);
    push_req(64'h5555_5555, 64'h55555);
    push_req(255, 1000);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    wait_drained();
    run_phase(0, 0);
    run_phase(85, 0);
    run_phase(0, 85);
    run_phase(10, 10);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS size_class_mapper");
    end else begin
      $display("FAIL size_class_mapper");
    end
    $finish;
  end

endmodule
